// ----- design/blde_pkg.sv -----
`timescale 1ns / 1ps
package blde_pkg;

  // item function codes
  localparam logic [1:0] FUNC_DRAW  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam int PcW = 4;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_LATCH,
    ACT_SETUP,
    ACT_MEM_RD,
    ACT_MEM_WR,
    ACT_PIX_RD,
    ACT_PIX_WR,
    ACT_RESULT
  } act_e;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_CLR_BUSY,
    COND_NO_IN,
    COND_IS_READ,
    COND_IS_WRITE,
    COND_IS_SPARE,
    COND_NOT_AT_END,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    act_e           act;
    cond_e          cond;
    logic [PcW-1:0] target;
  } uword_t;

  // program step addresses
  localparam logic [PcW-1:0] StepClear   = 4'd0;
  localparam logic [PcW-1:0] StepFetch   = 4'd1;
  localparam logic [PcW-1:0] StepDispRd  = 4'd2;
  localparam logic [PcW-1:0] StepDispWr  = 4'd3;
  localparam logic [PcW-1:0] StepDispSp  = 4'd4;
  localparam logic [PcW-1:0] StepSetup   = 4'd5;
  localparam logic [PcW-1:0] StepMemRd   = 4'd6;
  localparam logic [PcW-1:0] StepMemWr   = 4'd7;
  localparam logic [PcW-1:0] StepPixRd   = 4'd8;
  localparam logic [PcW-1:0] StepPixWr   = 4'd9;
  localparam logic [PcW-1:0] StepResult  = 4'd10;
  localparam logic [PcW-1:0] StepRestart = 4'd11;

  // control store: jump to target when cond holds, else fall through
  function automatic uword_t rom_word(input logic [PcW-1:0] pc);
    uword_t w;
    w = '{act: ACT_NONE, cond: COND_ALWAYS, target: StepFetch};
    unique case (pc)
      StepClear:   w = '{act: ACT_CLEAR,  cond: COND_CLR_BUSY,   target: StepClear};
      StepFetch:   w = '{act: ACT_LATCH,  cond: COND_NO_IN,      target: StepFetch};
      StepDispRd:  w = '{act: ACT_NONE,   cond: COND_IS_READ,    target: StepMemRd};
      StepDispWr:  w = '{act: ACT_NONE,   cond: COND_IS_WRITE,   target: StepMemWr};
      StepDispSp:  w = '{act: ACT_NONE,   cond: COND_IS_SPARE,   target: StepResult};
      StepSetup:   w = '{act: ACT_SETUP,  cond: COND_ALWAYS,     target: StepPixRd};
      StepMemRd:   w = '{act: ACT_MEM_RD, cond: COND_ALWAYS,     target: StepResult};
      StepMemWr:   w = '{act: ACT_MEM_WR, cond: COND_ALWAYS,     target: StepResult};
      StepPixRd:   w = '{act: ACT_PIX_RD, cond: COND_NEVER,      target: StepPixRd};
      StepPixWr:   w = '{act: ACT_PIX_WR, cond: COND_NOT_AT_END, target: StepPixRd};
      StepResult:  w = '{act: ACT_RESULT, cond: COND_OUT_BUSY,   target: StepResult};
      StepRestart: w = '{act: ACT_NONE,   cond: COND_ALWAYS,     target: StepFetch};
      default:     w = '{act: ACT_NONE,   cond: COND_ALWAYS,     target: StepFetch};
    endcase
    return w;
  endfunction

endpackage

// ----- design/blde_ram.sv -----
`timescale 1ns / 1ps
module blde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic                             re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/bitmap_line_draw_engine.sv -----
`timescale 1ns / 1ps
// channel  | direction | handshake             | word
// ---------+-----------+-----------------------+-----------------------------------------
// in       | input     | in_valid_i/in_ready_o | func, start/end point, pixel, index, data
// out      | output    | out_valid_o/out_ready_i | read_data, done_kind
//
// one item at a time; a line reads then writes the frame word for each pixel
// through the single memory port
// after reset the sequencer clears the frame, one word a cycle,
// all WORDS_PER_ROW*ROWS words (2048 by default), with in_ready_o low
// a result waiting in the output register holds the next item only at its result step
module bitmap_line_draw_engine #(
  parameter int WORDS_PER_ROW = 16,
  parameter int ROWS          = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  start_x_i,
  input  logic [6:0]  start_y_i,
  input  logic [7:0]  end_x_i,
  input  logic [6:0]  end_y_i,
  input  logic        pixel_value_i,
  input  logic [10:0] word_index_i,
  input  logic [15:0] word_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] read_data_o,
  output logic [1:0]  done_kind_o
);
  import blde_pkg::*;

  localparam int Depth = WORDS_PER_ROW * ROWS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  logic [PcW-1:0]   pc_q, pc_d;
  uword_t           uw;
  logic [AddrW-1:0] clr_q;

  logic [1:0]  func_q;
  logic [7:0]  x_q, xe_q, px_q;
  logic [6:0]  y_q, ye_q, py_q;
  logic [7:0]  dx_q;
  logic [6:0]  dy_q;
  logic        sx_neg_q, sy_neg_q;
  logic signed [11:0] err_q;
  logic        pix_q;
  logic [10:0] idx_q;
  logic [15:0] wdata_q;
  logic [AddrW-1:0] addr_q;
  logic [15:0] mask_q;
  logic        hit_q;

  logic        out_valid_q;
  logic [15:0] read_data_q;
  logic [1:0]  done_kind_q;

  logic        out_free, at_end, jump;
  logic        idx_hit, pix_hit;
  logic [15:0] idx_wide, pix_wide;
  logic [AddrW-1:0] idx_addr, pix_addr;

  logic [7:0]  dx_new;
  logic [6:0]  dy_new;
  logic signed [12:0] e2, dx13, dy13, err_n;
  logic        step_x, step_y;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_addr;
  logic [15:0]      ram_wdata, ram_rdata;

  assign uw       = rom_word(pc_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign at_end   = (x_q == xe_q) && (y_q == ye_q);

  always_comb begin
    unique case (uw.cond)
      COND_NEVER:      jump = 1'b0;
      COND_ALWAYS:     jump = 1'b1;
      COND_CLR_BUSY:   jump = (clr_q != LastAddr);
      COND_NO_IN:      jump = !in_valid_i;
      COND_IS_READ:    jump = (func_q == FUNC_READ);
      COND_IS_WRITE:   jump = (func_q == FUNC_WRITE);
      COND_IS_SPARE:   jump = (func_q == FUNC_SPARE);
      COND_NOT_AT_END: jump = !at_end;
      COND_OUT_BUSY:   jump = !out_free;
      default:         jump = 1'b1;
    endcase
    pc_d = jump ? uw.target : pc_q + PcW'(1);
  end

  // word address of an item, and of the pixel at (px, py)
  assign idx_wide = 16'(idx_q);
  assign idx_addr = idx_wide[AddrW-1:0];
  assign idx_hit  = (32'(idx_q) < Depth);
  assign pix_wide = 16'(py_q) * 16'(WORDS_PER_ROW) + 16'(px_q[7:4]);
  assign pix_addr = pix_wide[AddrW-1:0];
  assign pix_hit  = (32'(px_q[7:4]) < WORDS_PER_ROW) && (32'(py_q) < ROWS);

  // bresenham step
  assign dx_new = (end_x_i > start_x_i) ? end_x_i - start_x_i : start_x_i - end_x_i;
  assign dy_new = (end_y_i > start_y_i) ? end_y_i - start_y_i : start_y_i - end_y_i;
  always_comb begin
    e2     = $signed({err_q, 1'b0});
    dx13   = $signed({5'b0, dx_q});
    dy13   = $signed({6'b0, dy_q});
    step_x = (e2 > -dy13);
    step_y = (e2 < dx13);
    err_n  = 13'(err_q);
    if (step_x) begin
      err_n = err_n - dy13;
    end
    if (step_y) begin
      err_n = err_n + dx13;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = pix_addr;
    ram_wdata = '0;
    unique case (uw.act)
      ACT_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
      end
      ACT_MEM_RD: begin
        ram_re   = 1'b1;
        ram_addr = idx_addr;
      end
      ACT_MEM_WR: begin
        ram_we    = idx_hit;
        ram_addr  = idx_addr;
        ram_wdata = wdata_q;
      end
      ACT_PIX_RD: begin
        ram_re   = 1'b1;
        ram_addr = pix_addr;
      end
      ACT_PIX_WR: begin
        ram_we    = hit_q;
        ram_addr  = addr_q;
        ram_wdata = pix_q ? (ram_rdata | mask_q) : (ram_rdata & ~mask_q);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  blde_ram #(
    .WIDTH (16),
    .DEPTH (Depth)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= StepClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (uw.act == ACT_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (uw.act)
        ACT_CLEAR: begin
          clr_q <= clr_q + AddrW'(1);
        end
        ACT_LATCH: begin
          if (in_valid_i) begin
            func_q  <= func_i;
            x_q     <= start_x_i;
            y_q     <= start_y_i;
            xe_q    <= end_x_i;
            ye_q    <= end_y_i;
            pix_q   <= pixel_value_i;
            idx_q   <= word_index_i;
            wdata_q <= word_data_i;
            dx_q    <= dx_new;
            dy_q    <= dy_new;
          end
        end
        ACT_SETUP: begin
          // the end point is plotted first
          sx_neg_q <= !(x_q < xe_q);
          sy_neg_q <= !(y_q < ye_q);
          err_q    <= $signed({4'b0, dx_q}) - $signed({5'b0, dy_q});
          px_q     <= xe_q;
          py_q     <= ye_q;
        end
        ACT_MEM_RD: begin
          hit_q <= idx_hit;
        end
        ACT_PIX_RD: begin
          addr_q <= pix_addr;
          mask_q <= 16'(1) << px_q[3:0];
          hit_q  <= pix_hit;
        end
        ACT_PIX_WR: begin
          if (!at_end) begin
            px_q  <= x_q;
            py_q  <= y_q;
            err_q <= 12'(err_n);
            if (step_x) begin
              x_q <= sx_neg_q ? x_q - 8'd1 : x_q + 8'd1;
            end
            if (step_y) begin
              y_q <= sy_neg_q ? y_q - 7'd1 : y_q + 7'd1;
            end
          end
        end
        ACT_RESULT: begin
          if (out_free) begin
            done_kind_q <= func_q;
            read_data_q <= (func_q == FUNC_READ && hit_q) ? ram_rdata : 16'd0;
          end
        end
        default: begin
          clr_q <= clr_q;
        end
      endcase
    end
  end

  assign in_ready_o  = (uw.act == ACT_LATCH);
  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign done_kind_o = done_kind_q;

endmodule

// ----- design/blde_checker.sv -----
`timescale 1ns / 1ps
module blde_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] read_data_o,
  input logic [1:0]  done_kind_o
);
  import blde_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o)
      && $stable(done_kind_o))
    else $error("result word changed while stalled");

  // only read items carry data
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (done_kind_o != FUNC_READ) |-> read_data_o == 16'd0)
    else $error("non-read result with nonzero data");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on back-to-back cycles");

endmodule

bind bitmap_line_draw_engine blde_checker u_blde_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import blde_pkg::*;

  localparam int FrameCols  = 256;
  localparam int FrameRows  = 128;
  localparam int FrameWords = 2048;
  localparam int NumRandom  = 1600;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  sx;
    logic [6:0]  sy;
    logic [7:0]  ex;
    logic [6:0]  ey;
    logic        pix;
    logic [10:0] idx;
    logic [15:0] data;
    bit          typed;
    logic [15:0] typed_data;
  } frame_op_t;

  typedef struct {
    logic [15:0] data;
    logic [1:0]  kind;
  } done_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = FUNC_SPARE;
  logic [7:0]  start_x_i = '0;
  logic [6:0]  start_y_i = '0;
  logic [7:0]  end_x_i = '0;
  logic [6:0]  end_y_i = '0;
  logic        pixel_value_i = 1'b0;
  logic [10:0] word_index_i = '0;
  logic [15:0] word_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] read_data_o;
  logic [1:0]  done_kind_o;

  logic [15:0] frame_mem [FrameWords];
  int          recent_addr [$];
  done_word_t  pending_done [$];
  frame_op_t   directed_ops [$];
  done_word_t  got_word;

  int  n_errors = 0;
  int  n_accepted = 0;
  int  n_results = 0;
  int  n_lines = 0;
  int  n_pixels = 0;
  int  n_reads = 0;
  int  n_writes = 0;
  int  n_spare = 0;
  int  burst_left = 0;
  logic hold_out = 1'b0;

  bitmap_line_draw_engine i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .pixel_value_i(pixel_value_i),
    .word_index_i (word_index_i),
    .word_data_i  (word_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_o  (read_data_o),
    .done_kind_o  (done_kind_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

  function automatic void note_addr(int addr);
    if (recent_addr.size() >= 64) void'(recent_addr.pop_front());
    recent_addr.push_back(addr);
  endfunction

  function automatic void plot_pixel(int x, int y, logic val);
    int addr;
    if (x < 0 || y < 0 || x >= FrameCols || y >= FrameRows) return;
    addr = y * 16 + x / 16;
    frame_mem[addr][x % 16] = val;
    n_pixels++;
    note_addr(addr);
  endfunction

  // bresenham walk, end point plotted first, start point on the first step
  function automatic void trace_line(int x, int y, int xe, int ye, logic val);
    int dx, dy, sx, sy, err, e2;
    dx = (xe > x) ? xe - x : x - xe;
    dy = (ye > y) ? ye - y : y - ye;
    sx = (x < xe) ? 1 : -1;
    sy = (y < ye) ? 1 : -1;
    err = dx - dy;
    plot_pixel(xe, ye, val);
    while (x != xe || y != ye) begin
      e2 = err * 2;
      plot_pixel(x, y, val);
      if (e2 > -dy) begin
        err -= dy;
        x += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y += sy;
      end
    end
  endfunction

  function automatic done_word_t run_frame_op(frame_op_t op);
    done_word_t d;
    d.data = '0;
    d.kind = op.func;
    case (op.func)
      FUNC_DRAW: begin
        trace_line(int'(op.sx), int'(op.sy), int'(op.ex), int'(op.ey), op.pix);
        n_lines++;
      end
      FUNC_READ: begin
        d.data = frame_mem[op.idx];
        n_reads++;
      end
      FUNC_WRITE: begin
        frame_mem[op.idx] = op.data;
        note_addr(int'(op.idx));
        n_writes++;
      end
      default: n_spare++;
    endcase
    return d;
  endfunction

  function automatic int clamp_coord(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void add_row(logic [1:0] func, int sx, int sy, int ex, int ey,
                                  logic pix, int idx, int data, bit typed, int typed_data);
    frame_op_t op;
    op.func = func;
    op.sx = sx[7:0];
    op.sy = sy[6:0];
    op.ex = ex[7:0];
    op.ey = ey[6:0];
    op.pix = pix;
    op.idx = idx[10:0];
    op.data = data[15:0];
    op.typed = typed;
    op.typed_data = typed_data[15:0];
    directed_ops.push_back(op);
  endfunction

  task automatic make_random_op(output frame_op_t op);
    int pick, span;
    op.sx = 8'($urandom_range(0, 255));
    op.sy = 7'($urandom_range(0, 127));
    op.ex = 8'($urandom_range(0, 255));
    op.ey = 7'($urandom_range(0, 127));
    op.pix = 1'($urandom_range(0, 1));
    op.idx = 11'($urandom_range(0, FrameWords - 1));
    op.data = 16'($urandom_range(0, 65535));
    op.typed = 1'b0;
    op.typed_data = '0;
    pick = $urandom_range(0, 99);
    if (pick < 40) op.func = FUNC_DRAW;
    else if (pick < 70) op.func = FUNC_READ;
    else if (pick < 90) op.func = FUNC_WRITE;
    else op.func = FUNC_SPARE;
    // mostly short lines keep the run length down, a few span the frame
    if (op.func == FUNC_DRAW && $urandom_range(0, 4) != 0) begin
      span = $urandom_range(0, 24);
      op.ex = 8'(clamp_coord(int'(op.sx) + $urandom_range(0, 2 * span) - span, 255));
      op.ey = 7'(clamp_coord(int'(op.sy) + $urandom_range(0, 2 * span) - span, 127));
    end
    // aim non-draw items at words that lines and writes recently touched
    if (op.func != FUNC_DRAW && recent_addr.size() > 0 && $urandom_range(0, 3) != 0)
      op.idx = 11'(recent_addr[$urandom_range(0, recent_addr.size() - 1)]);
    if (op.func == FUNC_WRITE && $urandom_range(0, 7) == 0)
      op.data = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
  endtask

  task automatic send_op(input frame_op_t op);
    done_word_t d;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    func_i <= op.func;
    start_x_i <= op.sx;
    start_y_i <= op.sy;
    end_x_i <= op.ex;
    end_y_i <= op.ey;
    pixel_value_i <= op.pix;
    word_index_i <= op.idx;
    word_data_i <= op.data;
    do @(posedge clk_i); while (!in_ready_o);
    d = run_frame_op(op);
    if (op.typed) d.data = op.typed_data;
    pending_done.push_back(d);
    n_accepted++;
  endtask

  task automatic flag_error(input string what);
    n_errors++;
    if (n_errors <= 10) $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_done.size() == 0) begin
        flag_error($sformatf("unexpected word data=%h kind=%0d", read_data_o, done_kind_o));
      end else begin
        got_word = pending_done.pop_front();
        if (read_data_o !== got_word.data || done_kind_o !== got_word.kind)
          flag_error($sformatf("result %0d: expected data=%h kind=%0d, got data=%h kind=%0d",
                               n_results, got_word.data, got_word.kind,
                               read_data_o, done_kind_o));
      end
    end
  end

  // output side stalls in randomly chosen modes: always ready, ready at random, or mostly stalled
  initial begin
    int mode, mode_left;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      if (hold_out) out_ready_i <= 1'b0;
      else case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // one long back-pressure stretch while the sender keeps offering words
  initial begin
    wait (n_accepted >= 400);
    @(posedge clk_i);
    hold_out <= 1'b1;
    repeat (600) @(posedge clk_i);
    hold_out <= 1'b0;
  end

  initial begin
    frame_op_t op;
    int guard;
    foreach (frame_mem[i]) frame_mem[i] = '0;

    add_row(FUNC_READ,    0,   0,   0,   0, 1'b0,    0,      0, 1'b1, 16'h0000);
    add_row(FUNC_READ,    0,   0,   0,   0, 1'b0, 2047,      0, 1'b1, 16'h0000);
    add_row(FUNC_SPARE, 255, 127, 255, 127, 1'b1, 2047, 16'hFFFF, 1'b1, 16'h0000);
    add_row(FUNC_WRITE,   0,   0,   0,   0, 1'b0,    0, 16'hFFFF, 1'b1, 16'h0000);
    add_row(FUNC_READ,    0,   0,   0,   0, 1'b0,    0,      0, 1'b1, 16'hFFFF);
    add_row(FUNC_WRITE,   0,   0,   0,   0, 1'b0, 2047, 16'hA5A5, 1'b1, 16'h0000);
    add_row(FUNC_READ,    0,   0,   0,   0, 1'b0, 2047,      0, 1'b1, 16'hA5A5);
    add_row(FUNC_WRITE,   0,   0,   0,   0, 1'b0,    1, 16'h0000, 1'b1, 16'h0000);
    // single-point line
    add_row(FUNC_DRAW,   20,   3,  20,   3, 1'b1,    0,      0, 1'b1, 16'h0000);
    add_row(FUNC_READ,    0,   0,   0,   0, 1'b0,   49,      0, 1'b1, 16'h0010);
    add_row(FUNC_DRAW,    0,   5, 255,   5, 1'b1,    0,      0, 1'b1, 16'h0000);
    add_row(FUNC_READ,    0,   0,   0,   0, 1'b0,   95,      0, 1'b1, 16'hFFFF);
    add_row(FUNC_READ,    0,   0,   0,   0, 1'b0,   80,      0, 1'b1, 16'hFFFF);
    add_row(FUNC_DRAW,  255, 127,   0,   0, 1'b1,    0,      0, 1'b1, 16'h0000);
    add_row(FUNC_READ,    0,   0,   0,   0, 1'b0, 2047,      0, 1'b0, 0);
    add_row(FUNC_DRAW,    7,   0,   7, 127, 1'b0,    0,      0, 1'b1, 16'h0000);
    add_row(FUNC_READ,    0,   0,   0,   0, 1'b0,   80,      0, 1'b1, 16'hFF7F);
    add_row(FUNC_DRAW,    0, 127, 255,   0, 1'b1, 2047, 16'hFFFF, 1'b1, 16'h0000);
    add_row(FUNC_READ,    0,   0,   0,   0, 1'b0, 2032,      0, 1'b0, 0);
    add_row(FUNC_DRAW,   10, 100,  13,  90, 1'b1,    0,      0, 1'b0, 0);
    add_row(FUNC_READ,    0,   0,   0,   0, 1'b0, 1440,      0, 1'b0, 0);
    add_row(FUNC_SPARE,   0,   0,   0,   0, 1'b0,    0,      0, 1'b1, 16'h0000);
    add_row(FUNC_DRAW,  200,  60, 190,  61, 1'b0,    0,      0, 1'b0, 0);
    add_row(FUNC_READ,    0,   0,   0,   0, 1'b0,  972,      0, 1'b0, 0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_ops[i]) send_op(directed_ops[i]);
    for (int n = 0; n < NumRandom; n++) begin
      make_random_op(op);
      send_op(op);
    end
    in_valid_i <= 1'b0;

    guard = 0;
    while (pending_done.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
    if (pending_done.size() != 0)
      flag_error($sformatf("%0d expected words never arrived", pending_done.size()));

    $display("%0d words in: %0d lines (%0d pixels), %0d reads, %0d writes, %0d spare",
             n_accepted, n_lines, n_pixels, n_reads, n_writes, n_spare);
    $display("%0d result words checked, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
